// ===== rtl/core/rdsc_pkg.sv =====
// Shared types, constants and helper functions for the radix digit string converter.
`default_nettype none

package rdsc_pkg;

    localparam logic [4:0] RADIX_RESET = 5'd10;
    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'd16;
    localparam logic [3:0] DEC_LIMIT   = 4'd10;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ALPHA  = 8'h41;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic [4:0] radix;
        logic       is_zero;
    } cmd_ctl_t;

    function automatic logic [4:0] clamp_radix(input logic [4:0] r);
        logic [4:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] res;
        if (d < DEC_LIMIT)
            res = CHAR_ZERO + 8'(d);
        else
            res = CHAR_ALPHA + 8'(d - DEC_LIMIT);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdsc_front.sv =====
// Front end: radix register, input word capture and classification.
`default_nettype none

module rdsc_front
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [4:0]            cfg_wdata,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  push,
    output      logic                  full,
    input  wire logic                  q_full,
    output      logic                  q_push,
    output      logic [VALUE_BITS-1:0] q_value,
    output      cmd_ctl_t              q_ctl
);

    logic [4:0]            radix_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    cmd_ctl_t              ctl_reg;
    logic                  accept;

    assign q_push  = valid_reg && !q_full;
    assign full    = valid_reg && q_full;
    assign accept  = push && !full;
    assign q_value = value_reg;
    assign q_ctl   = ctl_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                radix_reg <= cfg_wdata;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg       <= value;
            ctl_reg.radix   <= clamp_radix(radix_reg);
            ctl_reg.is_zero <= (value == '0);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_cmd_queue.sv =====
// Two-entry command queue between the front and back ends.
`default_nettype none

module rdsc_cmd_queue
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire cmd_ctl_t              wr_ctl,
    output      logic                  q_full,
    input  wire logic                  rd_en,
    output      logic                  q_empty,
    output      logic [VALUE_BITS-1:0] rd_value,
    output      cmd_ctl_t              rd_ctl
);

    logic [VALUE_BITS-1:0] value_reg [2];
    cmd_ctl_t              ctl_reg   [2];
    logic                  wp_reg;
    logic                  rp_reg;
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic                  do_wr;
    logic                  do_rd;

    assign q_full   = (cnt_reg == 2'd2);
    assign q_empty  = (cnt_reg == 2'd0);
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_value = value_reg[rp_reg];
    assign rd_ctl   = ctl_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 2'd1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= !wp_reg;
            if (do_rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            value_reg[wp_reg] <= wr_value;
            ctl_reg[wp_reg]   <= wr_ctl;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_back.sv =====
// Back end: radix divider, digit stack and character output queue.
`default_nettype none

module rdsc_back
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_empty,
    input  wire logic [VALUE_BITS-1:0] cmd_value,
    input  wire cmd_ctl_t              cmd_ctl,
    output      logic                  cmd_pop,
    output      logic [7:0]            character,
    output      logic                  last_char,
    output      logic                  empty,
    input  wire logic                  pop
);

    localparam int DIV_STEP   = 8;
    localparam int NCHUNK     = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PADW       = NCHUNK * DIV_STEP;
    localparam int CHW        = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SW         = $clog2(MAX_DIGITS);
    localparam int CW         = $clog2(MAX_DIGITS + 1);
    localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCHUNK - 1);
    localparam logic [CW-1:0]  LAST_SLOT  = CW'(MAX_DIGITS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

    state_t          state_reg, state_next;
    logic [PADW-1:0] w_reg, w_next;
    logic [4:0]      r_reg, r_next;
    logic [4:0]      d_reg, d_next;
    logic [CHW-1:0]  chunk_reg, chunk_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   ep_reg, ep_next;
    logic [CW-1:0]   ep_dec;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;

    logic [PADW-1:0] step_w;
    logic [4:0]      step_r;
    logic [4:0]      trial;
    logic            div_done;

    logic [3:0]      stack_reg [MAX_DIGITS];
    logic            wr_en;
    logic [SW-1:0]   wr_addr;
    logic [3:0]      wr_data;
    logic            rd_en;
    logic [SW-1:0]   rd_addr;
    logic [3:0]      rd_data_reg;

    logic [7:0]      out_char_reg [2];
    logic            out_last_reg [2];
    logic            out_wp_reg;
    logic            out_rp_reg;
    logic [1:0]      out_cnt_reg, out_cnt_next;
    logic            pop_fire;
    logic [2:0]      out_space;
    logic            can_issue;

    // 8 restoring divide steps per cycle on the 5-bit partial remainder
    always_comb
    begin
        step_w = w_reg;
        step_r = r_reg;
        trial  = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial  = {step_r[3:0], step_w[PADW-1]};
            step_w = {step_w[PADW-2:0], 1'b0};
            if (trial >= d_reg)
            begin
                step_r    = trial - d_reg;
                step_w[0] = 1'b1;
            end
            else
            begin
                step_r = trial;
            end
        end
    end

    assign div_done  = (step_w == '0) || (cnt_reg == LAST_SLOT);
    assign ep_dec    = ep_reg - CW'(1);
    assign rd_addr   = ep_dec[SW-1:0];
    assign pop_fire  = pop && !empty;
    assign out_space = {1'b0, out_cnt_reg} + {2'b00, pend_reg};
    assign can_issue = (out_space < 3'd2) || ((out_space == 3'd2) && pop_fire);

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        d_next         = d_reg;
        chunk_next     = chunk_reg;
        cnt_next       = cnt_reg;
        ep_next        = ep_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[SW-1:0];
        wr_data        = step_r[3:0];
        rd_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    w_next     = PADW'(cmd_value);
                    r_next     = '0;
                    d_next     = cmd_ctl.radix;
                    chunk_next = '0;
                    cnt_next   = '0;
                    if (cmd_ctl.is_zero)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = '0;
                        ep_next    = CW'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                w_next     = step_w;
                r_next     = step_r;
                chunk_next = chunk_reg + CHW'(1);
                if (chunk_reg == LAST_CHUNK)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    r_next     = '0;
                    chunk_next = '0;
                    if (div_done)
                    begin
                        ep_next    = cnt_reg + CW'(1);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_issue)
                begin
                    rd_en          = 1'b1;
                    ep_next        = ep_dec;
                    pend_next      = 1'b1;
                    pend_last_next = (ep_dec == '0);
                    if (ep_dec == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            ep_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            cnt_reg       <= cnt_next;
            ep_reg        <= ep_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // digit stack
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= stack_reg[rd_addr];
    end

    // character output queue
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (pend_reg && !pop_fire)
            out_cnt_next = out_cnt_reg + 2'd1;
        else if (pop_fire && !pend_reg)
            out_cnt_next = out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wp_reg  <= 1'b0;
            out_rp_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (pend_reg)
                out_wp_reg <= !out_wp_reg;
            if (pop_fire)
                out_rp_reg <= !out_rp_reg;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_char_reg[out_wp_reg] <= digit_glyph(rd_data_reg);
            out_last_reg[out_wp_reg] <= pend_last_reg;
        end
    end

    assign empty     = (out_cnt_reg == 2'd0);
    assign character = out_char_reg[out_rp_reg];
    assign last_char = out_last_reg[out_rp_reg];

`ifndef SYNTHESIS
    a_out_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_pend_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_cnt_reg != 2'd2))
        else $error("stack read returned with output queue full");

    a_div_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (d_reg >= RADIX_MIN && d_reg <= RADIX_MAX))
        else $error("divisor outside legal radix range");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ep_reg != '0))
        else $error("emit state with no digits left");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DIGITS))
        else $error("digit count exceeds stack depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/radix_digit_string_converter.sv =====
// Top level of the radix digit string converter.
// Flow: a pushed word is registered in the front end and passes through the command queue to the divider,
// which works through NCHUNK = ceil(VALUE_BITS/8) chunks per digit; digits then go from the stack to the output queue.
// New words are buffered in the front register and command queue while the back end converts a word.
// Reset: async active low; radix returns to 10, all queues empty, digit stack left as is.
`default_nettype none

module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [4:0]            cfg_wdata,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  push,
    output      logic                  full,
    output      logic [7:0]            character,
    output      logic                  last_char,
    output      logic                  empty,
    input  wire logic                  pop
);

    logic                  q_full;
    logic                  q_push;
    logic [VALUE_BITS-1:0] q_wr_value;
    cmd_ctl_t              q_wr_ctl;
    logic                  q_empty;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] q_rd_value;
    cmd_ctl_t              q_rd_ctl;

    rdsc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value     (value),
        .push      (push),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_value   (q_wr_value),
        .q_ctl     (q_wr_ctl)
    );

    rdsc_cmd_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_value (q_wr_value),
        .wr_ctl   (q_wr_ctl),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .q_empty  (q_empty),
        .rd_value (q_rd_value),
        .rd_ctl   (q_rd_ctl)
    );

    rdsc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd_value (q_rd_value),
        .cmd_ctl   (q_rd_ctl),
        .cmd_pop   (q_pop),
        .character (character),
        .last_char (last_char),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ===== sim/radix_digit_string_converter_test.sv =====
// Self-checking testbench for radix_digit_string_converter: digit strings in selected and random radix settings.
`timescale 1ns / 100ps

module radix_digit_string_converter_test
    import rdsc_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          MAX_DIGITS  = 32;
    localparam int          TAIL_CYCLES = 200;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic [31:0] value = 32'd0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  character;
    logic        last_char;
    logic        empty;
    logic        pop = 1'b0;

    char_word_t  expected_chars[$];
    logic [4:0]  radix_setting = RADIX_RESET;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_cycles = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;

    radix_digit_string_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value     (value),
        .push      (push),
        .full      (full),
        .character (character),
        .last_char (last_char),
        .empty     (empty),
        .pop       (pop)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Digit string of v in the current radix, most significant digit first.
    function automatic void predict_digits(input logic [31:0] v);
        logic [3:0]  digits[$];
        logic [3:0]  d;
        logic [63:0] rest;
        int unsigned base;
        char_word_t  w;
        base = (radix_setting < RADIX_MIN) ? RADIX_MIN :
               (radix_setting > RADIX_MAX) ? RADIX_MAX : radix_setting;
        rest = {32'd0, v};
        do
        begin
            digits.push_back(4'(rest % base));
            rest = rest / base;
        end
        while (rest != 0 && digits.size() < MAX_DIGITS);
        while (digits.size() > 0)
        begin
            d = digits.pop_back();
            w.character = (d < DEC_LIMIT) ? CHAR_ZERO + 8'(d) : CHAR_ALPHA + 8'(d - DEC_LIMIT);
            w.last_char = (digits.size() == 0);
            expected_chars.push_back(w);
        end
    endfunction

    function automatic logic [31:0] random_value();
        logic [63:0] p;
        int unsigned base;
        logic [31:0] v;
        base = (radix_setting < RADIX_MIN) ? RADIX_MIN :
               (radix_setting > RADIX_MAX) ? RADIX_MAX : radix_setting;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2: v = $urandom_range(0, 40);
            default:
            begin
                // powers of the radix and one below, where the digit count steps
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p * base <= 64'hFFFF_FFFF)
                        p = p * base;
                v = 32'(p - $urandom_range(0, 1));
            end
        endcase
        return v;
    endfunction

    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles = rx_hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_chars
        char_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected word: character %h last_char %b", character, last_char);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.character)
                begin
                    $error("character: expected %h, got %h", want.character, character);
                    error_count++;
                end
                if (last_char !== want.last_char)
                begin
                    $error("last_char: expected %b, got %b", want.last_char, last_char);
                    error_count++;
                end
            end
        end
    end

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push  <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full);
        predict_digits(v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_radix(input logic [4:0] r);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        radix_setting = r;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_default_radix();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd1000000000);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_radix_range();
        set_radix(5'd2);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        set_radix(5'd16);
        send_value(32'd15);
        send_value(32'hABCD_EF01);
        send_value(32'hFFFF_FFFF);
        // below the lowest radix: behaves as binary
        set_radix(5'd0);
        send_value(32'd5);
        set_radix(5'd1);
        send_value(32'd6);
        // above the highest radix: behaves as hex
        set_radix(5'd17);
        send_value(32'hFEDC_BA98);
        set_radix(5'd31);
        send_value(32'h0123_4567);
        set_radix(5'd3);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (3)
        begin
            set_radix(5'($urandom_range(0, 31)));
            repeat (18) send_value(random_value());
        end
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_radix(5'd16);
        rx_hold_cycles = 1000;
        repeat (48) send_value(32'($urandom_range(0, 255)));
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_radix();
        test_radix_range();
        test_random_phase(32, 77);
        test_random_phase(77, 32);
        test_random_phase(0, 0);
        test_output_stall();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
